// ===== design/akc_pkg.sv =====
// ----------------------------------------------------------------------------
// akc_pkg: shared types and codes for the associative key cache
// Command and result codes, the stored entry layout and the
// controller/datapath interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package akc_pkg;

  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_FILL   = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_FILLED  = 3'd2;
  localparam logic [2:0] ST_IGNORED = 3'd3;
  localparam logic [2:0] ST_REMOVED = 3'd4;

  typedef struct packed {
    logic [15:0] device;
    logic [31:0] inode;
    logic [31:0] stamp;
    logic [31:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic load;      // latch a lookup or remove and start the scan
    logic fill_now;  // complete a fill or unused command at once
    logic scan;      // scan in progress
    logic finish;    // resolve the scan and emit the result
  } akc_cmd_t;

  typedef struct packed {
    logic done;      // first key match seen or last entry compared
  } akc_stat_t;

endpackage

`default_nettype wire

// ===== design/assoc_key_cache_rr_replace.sv =====
// ----------------------------------------------------------------------------
// assoc_key_cache_rr_replace: fully associative key cache
// Lookup, fill and remove on a small cache keyed by device and inode,
// with stamp checking and round-robin replacement.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Lookup and remove
// compare one stored entry per cycle through the single read port of the
// entry memory, from entry 0 upward, stopping at the first key match or
// at the last entry; busy is high while the scan runs, up to and including
// the cycle in which it resolves. Fill and the unused command are handled
// in the cycle they are taken and do not raise busy; their result is
// registered and follows in the next cycle. Each result is shown for one
// cycle with out_strobe and cannot be held off.
// Valid bits reset at once, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`default_nettype none

module assoc_key_cache_rr_replace
  import akc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_device_id,
  input  wire logic [31:0] in_inode_number,
  input  wire logic [31:0] in_mod_stamp,
  input  wire logic [31:0] in_fill_value,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [31:0]      out_hit_value
);

  akc_cmd_t  ctl;
  akc_stat_t stat;

  akc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .busy   (busy),
    .ctl    (ctl)
  );

  akc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             (ctl),
    .stat            (stat),
    .in_cmd          (in_cmd),
    .in_device_id    (in_device_id),
    .in_inode_number (in_inode_number),
    .in_mod_stamp    (in_mod_stamp),
    .in_fill_value   (in_fill_value),
    .out_strobe      (out_strobe),
    .out_status      (out_status),
    .out_hit_value   (out_hit_value)
  );

endmodule

`default_nettype wire

// ===== design/akc_ram.sv =====
// ----------------------------------------------------------------------------
// akc_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module akc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== design/akc_ctrl.sv =====
// ----------------------------------------------------------------------------
// akc_ctrl: command sequencer for the associative key cache
// Accepts commands, runs the entry scan for lookups and removes and
// tells the datapath when to resolve.
// ----------------------------------------------------------------------------
`default_nettype none

module akc_ctrl
  import akc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_cmd,
  input  wire akc_stat_t  stat,
  output logic            busy,
  output akc_cmd_t        ctl
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state_r, state_nxt;
  logic accept;
  logic is_scan_cmd;

  assign accept      = start && (state_r == S_IDLE);
  assign is_scan_cmd = (in_cmd == CMD_LOOKUP) || (in_cmd == CMD_REMOVE);
  assign busy        = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    ctl.load     = 1'b0;
    ctl.fill_now = 1'b0;
    ctl.scan     = 1'b0;
    ctl.finish   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_scan_cmd) begin
            ctl.load  = 1'b1;
            state_nxt = S_SCAN;
          end else begin
            ctl.fill_now = 1'b1;
          end
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (stat.done) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/akc_dp.sv =====
// ----------------------------------------------------------------------------
// akc_dp: datapath of the associative key cache
// Entry memory, valid bits, scan counters, victim choice, round-robin
// pointer, pending victim and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module akc_dp
  import akc_pkg::*;
#(
  parameter int ENTRIES = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire akc_cmd_t    ctl,
  output akc_stat_t        stat,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_device_id,
  input  wire logic [31:0] in_inode_number,
  input  wire logic [31:0] in_mod_stamp,
  input  wire logic [31:0] in_fill_value,
  output logic             out_strobe,
  output logic [2:0]       out_status,
  output logic [31:0]      out_hit_value
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  logic [ENTRIES-1:0] valid_r;
  logic [1:0]         cmd_r;
  logic [15:0]        dev_r;
  logic [31:0]        ino_r;
  logic [31:0]        stamp_r;
  logic [IDX_W-1:0]   issue_idx_r;
  logic               issue_en_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               cmp_en_r;
  logic               free_found_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic [IDX_W-1:0]   rr_ptr_r;
  logic               pend_valid_r;
  logic [IDX_W-1:0]   pend_slot_r;
  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [31:0]        out_hit_value_r;

  logic               ram_we;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd;

  logic match_now;
  logic inv_now;
  logic cmp_last;
  logic stamp_eq;
  logic do_fill;

  akc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_slot_r),
    .wdata (ram_wdata),
    .raddr (issue_idx_r),
    .rdata (ram_rdata)
  );

  assign rd        = entry_t'(ram_rdata);
  assign match_now = cmp_en_r && valid_r[cmp_idx_r] &&
                     (rd.device == dev_r) && (rd.inode == ino_r);
  assign inv_now   = cmp_en_r && !valid_r[cmp_idx_r];
  assign cmp_last  = (cmp_idx_r == LAST_IDX);
  assign stamp_eq  = (rd.stamp == stamp_r);
  assign stat.done = match_now || (cmp_en_r && cmp_last);

  assign do_fill   = ctl.fill_now && (in_cmd == CMD_FILL) && pend_valid_r;
  assign ram_we    = do_fill;

  always_comb begin
    ram_wdata.device = in_device_id;
    ram_wdata.inode  = in_inode_number;
    ram_wdata.stamp  = in_mod_stamp;
    ram_wdata.value  = in_fill_value;
  end

  // latched request
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r   <= in_cmd;
      dev_r   <= in_device_id;
      ino_r   <= in_inode_number;
      stamp_r <= in_mod_stamp;
    end
    cmp_idx_r <= issue_idx_r;
    if (!free_found_r && inv_now) begin
      free_idx_r <= cmp_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r         <= '0;
      issue_idx_r     <= '0;
      issue_en_r      <= 1'b0;
      cmp_en_r        <= 1'b0;
      free_found_r    <= 1'b0;
      rr_ptr_r        <= '0;
      pend_valid_r    <= 1'b0;
      pend_slot_r     <= '0;
      out_valid_r     <= 1'b0;
      out_status_r    <= ST_IGNORED;
      out_hit_value_r <= '0;
    end else begin
      out_valid_r <= ctl.fill_now || ctl.finish;

      // scan counters
      if (ctl.load) begin
        issue_idx_r  <= '0;
        issue_en_r   <= 1'b1;
        cmp_en_r     <= 1'b0;
        free_found_r <= 1'b0;
      end else if (ctl.finish) begin
        issue_en_r <= 1'b0;
        cmp_en_r   <= 1'b0;
      end else if (ctl.scan) begin
        cmp_en_r <= issue_en_r;
        if (issue_en_r) begin
          if (issue_idx_r == LAST_IDX) begin
            issue_en_r <= 1'b0;
          end else begin
            issue_idx_r <= issue_idx_r + 1'b1;
          end
        end
        if (inv_now) begin
          free_found_r <= 1'b1;
        end
      end

      // fill and unused command
      if (ctl.fill_now) begin
        out_hit_value_r <= '0;
        if (do_fill) begin
          valid_r[pend_slot_r] <= 1'b1;
          pend_valid_r         <= 1'b0;
          out_status_r         <= ST_FILLED;
        end else begin
          out_status_r <= ST_IGNORED;
        end
      end

      // scan resolution
      if (ctl.finish) begin
        if (cmd_r == CMD_LOOKUP) begin
          if (match_now && stamp_eq) begin
            out_status_r    <= ST_HIT;
            out_hit_value_r <= rd.value;
          end else begin
            out_status_r    <= ST_MISS;
            out_hit_value_r <= '0;
            pend_valid_r    <= 1'b1;
            if (match_now) begin
              valid_r[cmp_idx_r] <= 1'b0;
              pend_slot_r        <= cmp_idx_r;
            end else if (free_found_r) begin
              pend_slot_r <= free_idx_r;
            end else if (inv_now) begin
              pend_slot_r <= cmp_idx_r;
            end else begin
              pend_slot_r <= rr_ptr_r;
              rr_ptr_r    <= (rr_ptr_r == LAST_IDX) ? '0 : rr_ptr_r + 1'b1;
            end
          end
        end else begin
          out_status_r    <= ST_REMOVED;
          out_hit_value_r <= '0;
          if (match_now) begin
            valid_r[cmp_idx_r] <= 1'b0;
          end
        end
      end
    end
  end

  assign out_strobe    = out_valid_r;
  assign out_status    = out_status_r;
  assign out_hit_value = out_hit_value_r;

endmodule

`default_nettype wire
